// ----- hw/rtl/tme_pkg.sv -----
// tape machine execute unit: shared types, opcodes and command classes
// used by the front end, the command queue, the back end and the top level
package tme_pkg;

    localparam int TAPE_AW = 15;
    localparam int TAPE_DEPTH = 1 << TAPE_AW;
    localparam int AMT_W = 12;
    localparam int QAW = 2;
    localparam int QDEPTH = 1 << QAW;

    localparam logic [2:0] OP_RIGHT = 3'd0;
    localparam logic [2:0] OP_LEFT  = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_SUB   = 3'd3;
    localparam logic [2:0] OP_OUT   = 3'd4;
    localparam logic [2:0] OP_IN    = 3'd5;
    localparam logic [2:0] OP_OPEN  = 3'd6;
    localparam logic [2:0] OP_CLOSE = 3'd7;

    localparam logic [2:0] K_MOVE  = 3'd0;
    localparam logic [2:0] K_ADD   = 3'd1;
    localparam logic [2:0] K_SET   = 3'd2;
    localparam logic [2:0] K_OUT   = 3'd3;
    localparam logic [2:0] K_OPEN  = 3'd4;
    localparam logic [2:0] K_CLOSE = 3'd5;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [AMT_W-1:0] amount;
        logic [7:0]       in_byte;
    } cmd_t;

    typedef struct packed {
        logic       emit_valid;
        logic [7:0] emit_byte;
        logic       jump_taken;
    } res_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [TAPE_AW-1:0] addr;
        logic [7:0]         data;
    } qent_t;

    function automatic logic [TAPE_AW-1:0] step_of(input logic [AMT_W-1:0] amount);
        logic [AMT_W+TAPE_AW-1:0] ext;
        ext = (AMT_W + TAPE_AW)'(amount);
        return ext[TAPE_AW-1:0];
    endfunction

endpackage

// ----- hw/rtl/tme_front.sv -----
// front end: accepts commands, keeps the data pointer and classifies each
// command into a queue entry; depends on tme_pkg
module tme_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  tme_pkg::cmd_t cmd,
    input  logic          clear_done,
    input  logic          q_full,
    output logic          push,
    output tme_pkg::qent_t push_ent
);
    import tme_pkg::*;

    logic [TAPE_AW-1:0] ptr_reg;
    logic [TAPE_AW-1:0] ptr_next;
    logic [TAPE_AW-1:0] step;

    assign cmd_ready = clear_done && !q_full;
    assign push = cmd_valid && cmd_ready;
    assign step = step_of(cmd.amount);

    always_comb
    begin
        ptr_next = ptr_reg;
        push_ent.addr = ptr_reg;
        push_ent.kind = K_MOVE;
        push_ent.data = 8'd0;
        case (cmd.opcode)
            OP_RIGHT: ptr_next = ptr_reg + step;
            OP_LEFT:  ptr_next = ptr_reg - step;
            OP_ADD:
            begin
                push_ent.kind = K_ADD;
                push_ent.data = cmd.amount[7:0];
            end
            OP_SUB:
            begin
                push_ent.kind = K_ADD;
                push_ent.data = 8'd0 - cmd.amount[7:0];
            end
            OP_OUT:   push_ent.kind = K_OUT;
            OP_IN:
            begin
                push_ent.kind = K_SET;
                push_ent.data = cmd.in_byte;
            end
            OP_OPEN:  push_ent.kind = K_OPEN;
            OP_CLOSE: push_ent.kind = K_CLOSE;
            default:  push_ent.kind = K_MOVE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= '0;
        else if (push)
            ptr_reg <= ptr_next;
    end

endmodule

// ----- hw/rtl/tme_queue.sv -----
// short command queue between front end and back end
// depends on tme_pkg
module tme_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tme_pkg::qent_t push_ent,
    output logic           full,
    output logic           head_valid,
    output tme_pkg::qent_t head,
    input  logic           pop
);
    import tme_pkg::*;

    qent_t          q_mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   cnt_reg;
    logic [QAW:0]   cnt_next;

    assign full = (cnt_reg == (QAW + 1)'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head = q_mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= (QAW + 1)'(QDEPTH))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !head_valid))
        else $error("pop from empty queue");

endmodule

// ----- hw/rtl/tme_back.sv -----
// back end: tape memory with clearing pass, read-modify-write stage with
// write forwarding, and the result register; depends on tme_pkg
module tme_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  tme_pkg::qent_t head,
    output logic           pop,
    output logic           clear_done,
    output logic           res_valid,
    input  logic           res_ready,
    output tme_pkg::res_t  res
);
    import tme_pkg::*;

    logic [7:0]         tape_mem [TAPE_DEPTH];
    logic [TAPE_AW:0]   clr_cnt_reg;

    logic               s2_vld_reg;
    logic [2:0]         s2_kind_reg;
    logic [TAPE_AW-1:0] s2_addr_reg;
    logic [7:0]         s2_data_reg;
    logic               s2_fwd_reg;
    logic [7:0]         s2_fwd_data_reg;
    logic [7:0]         rd_data_reg;

    logic               res_vld_reg;
    res_t               res_reg;
    res_t               res_next;

    logic               fire;
    logic               s2_wr;
    logic [7:0]         cur_cell;
    logic [7:0]         new_cell;
    logic               wr_en;
    logic [TAPE_AW-1:0] wr_addr;
    logic [7:0]         wr_data;

    assign clear_done = clr_cnt_reg[TAPE_AW];
    assign fire = s2_vld_reg && (!res_vld_reg || res_ready);
    assign pop = clear_done && head_valid && (!s2_vld_reg || fire);
    assign cur_cell = s2_fwd_reg ? s2_fwd_data_reg : rd_data_reg;
    assign res_valid = res_vld_reg;
    assign res = res_reg;

    always_comb
    begin
        s2_wr = 1'b0;
        new_cell = cur_cell;
        res_next = '0;
        case (s2_kind_reg)
            K_ADD:
            begin
                s2_wr = 1'b1;
                new_cell = cur_cell + s2_data_reg;
            end
            K_SET:
            begin
                s2_wr = 1'b1;
                new_cell = s2_data_reg;
            end
            K_OUT:
            begin
                res_next.emit_valid = 1'b1;
                res_next.emit_byte = cur_cell;
            end
            K_OPEN:  res_next.jump_taken = (cur_cell == 8'd0);
            K_CLOSE: res_next.jump_taken = (cur_cell != 8'd0);
            default: s2_wr = 1'b0;
        endcase
    end

    always_comb
    begin
        if (!clear_done)
        begin
            wr_en = 1'b1;
            wr_addr = clr_cnt_reg[TAPE_AW-1:0];
            wr_data = 8'd0;
        end
        else
        begin
            wr_en = fire && s2_wr;
            wr_addr = s2_addr_reg;
            wr_data = new_cell;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tape_mem[wr_addr] <= wr_data;
        if (pop)
            rd_data_reg <= tape_mem[head.addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s2_kind_reg <= head.kind;
            s2_addr_reg <= head.addr;
            s2_data_reg <= head.data;
            s2_fwd_reg <= fire && s2_wr && (s2_addr_reg == head.addr);
            s2_fwd_data_reg <= new_cell;
        end
        if (fire)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            s2_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (!clear_done)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (pop)
                s2_vld_reg <= 1'b1;
            else if (fire)
                s2_vld_reg <= 1'b0;
            if (fire)
                res_vld_reg <= 1'b1;
            else if (res_ready)
                res_vld_reg <= 1'b0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !clear_done |-> !pop && !s2_vld_reg)
        else $error("command issued during clearing pass");
    assert property (@(posedge clk) disable iff (!rst_n) res_vld_reg && !res_ready |=> $stable(res_reg))
        else $error("held result changed");
    assert property (@(posedge clk) disable iff (!rst_n) clear_done |=> clear_done)
        else $error("clearing pass restarted");

endmodule

// ----- hw/rtl/tape_machine_execute_unit.sv -----
// tape machine execute unit top level: front end, command queue, back end
// depends on tme_pkg, tme_front, tme_queue, tme_back
// path: each accepted command goes through the queue and the read-modify-write stage into the result register
// throughput: one command per cycle while res_ready is high, set by the single tape read-modify-write stage
// reset: tape cleared by a pass over all 2**TAPE_AW cells (32768), cmd_ready low meanwhile
// reset also zeroes the data pointer and empties the queue and result register
module tape_machine_execute_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  tme_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output tme_pkg::res_t res
);
    import tme_pkg::*;

    logic  clear_done;
    logic  q_full;
    logic  push;
    qent_t push_ent;
    logic  head_valid;
    qent_t head;
    logic  pop;

    tme_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .clear_done (clear_done),
        .q_full     (q_full),
        .push       (push),
        .push_ent   (push_ent)
    );

    tme_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ent   (push_ent),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    tme_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .clear_done (clear_done),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule
